/* rtl/lcr_pkg.sv */
// Shared types, constants and outcode helpers for the line clip rectangle unit.
// No dependencies.
package lcr_pkg;

   localparam int COORD_BITS     = 20;
   localparam int MAX_CLIP_STEPS = 4;
   localparam int EDGE_BITS      = 16;
   localparam int FRAC_BITS      = 4;
   localparam int EDGE_Q_BITS    = EDGE_BITS + FRAC_BITS;
   localparam int WIDE_BITS      = 32;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [3:0] CODE_TOP    = 4'b1000;
   localparam logic [3:0] CODE_BOTTOM = 4'b0100;
   localparam logic [3:0] CODE_RIGHT  = 4'b0010;
   localparam logic [3:0] CODE_LEFT   = 4'b0001;

   localparam logic [1:0] REG_CLIP_TOP    = 2'd0;
   localparam logic [1:0] REG_CLIP_BOTTOM = 2'd1;
   localparam logic [1:0] REG_CLIP_LEFT   = 2'd2;
   localparam logic [1:0] REG_CLIP_RIGHT  = 2'd3;

   typedef struct packed {
      logic valid;
      logic done;
      logic visible;
   } status_type;

   function automatic logic signed [WIDE_BITS-1:0] edge_q(input logic signed [EDGE_BITS-1:0] e);
      edge_q = {{(WIDE_BITS-EDGE_Q_BITS){e[EDGE_BITS-1]}}, e, {FRAC_BITS{1'b0}}};
   endfunction

   function automatic logic [3:0] outcode(
      input logic signed [WIDE_BITS-1:0] x,
      input logic signed [WIDE_BITS-1:0] y,
      input logic signed [EDGE_BITS-1:0] top,
      input logic signed [EDGE_BITS-1:0] bottom,
      input logic signed [EDGE_BITS-1:0] left,
      input logic signed [EDGE_BITS-1:0] right);
      logic [3:0] code;
      code = '0;
      if (y < edge_q(top)) code = code | CODE_TOP;
      else if (y > edge_q(bottom)) code = code | CODE_BOTTOM;
      if (x < edge_q(left)) code = code | CODE_LEFT;
      else if (x > edge_q(right)) code = code | CODE_RIGHT;
      outcode = code;
   endfunction

endpackage

/* rtl/lcr_if.sv */
// Valid/ready channel interfaces for the line clip rectangle unit.
// Depends on lcr_pkg.
interface lcr_req_if #(parameter int COORD_BITS = lcr_pkg::COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lcr_rsp_if #(parameter int COORD_BITS = lcr_pkg::COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic signed [COORD_BITS-1:0] out_start_x;
   logic signed [COORD_BITS-1:0] out_start_y;
   logic signed [COORD_BITS-1:0] out_end_x;
   logic signed [COORD_BITS-1:0] out_end_y;
   modport source (output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                   input ready);
   modport sink (input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                 output ready);
endinterface

/* rtl/line_clip_rectangle_unit.sv */
// Line clip rectangle unit: Cohen-Sutherland clipping of one segment per transaction.
// Channels req_bus (endpoints in) and rsp_bus (visible flag and clipped endpoints out),
// both valid/ready; clip edges are written over the APB-style port.
// Pipeline: an input register, MAX_CLIP_STEPS clip rounds and an output register,
// with W = max(COORD_BITS, 20). Each clip round is an outcode and setup stage, a
// multiply stage, a pipelined divider of W + 1 one-bit stages and an update stage.
// One transaction per cycle unless stalled; every stage carries its own valid bit.
// Stall: while rsp_bus.valid is high and rsp_bus.ready low, the whole pipeline
// holds and req_bus.ready drops; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits and the clip edges to 0.
// Edges are compared as edge * 16 against Q16.4 coordinates; invisible segments
// return all coordinates as 0. Write edges only while the pipeline is empty.
module line_clip_rectangle_unit #(
   parameter int COORD_BITS     = lcr_pkg::COORD_BITS,
   parameter int MAX_CLIP_STEPS = lcr_pkg::MAX_CLIP_STEPS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lcr_req_if.sink                              req_bus,
   lcr_rsp_if.source                            rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lcr_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [lcr_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [lcr_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);

   localparam int CW = (COORD_BITS > lcr_pkg::EDGE_Q_BITS) ? COORD_BITS : lcr_pkg::EDGE_Q_BITS;
   localparam int EB = lcr_pkg::EDGE_BITS;

   logic signed [EB-1:0] clip_top_ff, clip_bottom_ff, clip_left_ff, clip_right_ff;
   logic                 csr_write;
   logic [1:0]           csr_index;
   logic signed [EB-1:0] csr_rd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_top_ff    <= '0;
         clip_bottom_ff <= '0;
         clip_left_ff   <= '0;
         clip_right_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lcr_pkg::REG_CLIP_TOP:    clip_top_ff    <= pwdata[EB-1:0];
            lcr_pkg::REG_CLIP_BOTTOM: clip_bottom_ff <= pwdata[EB-1:0];
            lcr_pkg::REG_CLIP_LEFT:   clip_left_ff   <= pwdata[EB-1:0];
            lcr_pkg::REG_CLIP_RIGHT:  clip_right_ff  <= pwdata[EB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lcr_pkg::REG_CLIP_TOP:    csr_rd = clip_top_ff;
         lcr_pkg::REG_CLIP_BOTTOM: csr_rd = clip_bottom_ff;
         lcr_pkg::REG_CLIP_LEFT:   csr_rd = clip_left_ff;
         lcr_pkg::REG_CLIP_RIGHT:  csr_rd = clip_right_ff;
         default:                  csr_rd = '0;
      endcase
      prdata = lcr_pkg::CSR_DATA_BITS'(csr_rd);
   end

   logic rsp_valid_ff;
   logic advance;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   lcr_pkg::status_type  st_w [MAX_CLIP_STEPS+1];
   logic signed [CW-1:0] x0_w [MAX_CLIP_STEPS+1];
   logic signed [CW-1:0] y0_w [MAX_CLIP_STEPS+1];
   logic signed [CW-1:0] x1_w [MAX_CLIP_STEPS+1];
   logic signed [CW-1:0] y1_w [MAX_CLIP_STEPS+1];

   lcr_pkg::status_type  st_in_ff;
   logic signed [CW-1:0] x0_in_ff, y0_in_ff, x1_in_ff, y1_in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_in_ff <= '0;
      end else if (advance) begin
         st_in_ff <= '{valid: req_bus.valid, done: 1'b0, visible: 1'b0};
      end
      if (advance) begin
         x0_in_ff <= CW'(req_bus.start_x);
         y0_in_ff <= CW'(req_bus.start_y);
         x1_in_ff <= CW'(req_bus.end_x);
         y1_in_ff <= CW'(req_bus.end_y);
      end
   end

   assign st_w[0] = st_in_ff;
   assign x0_w[0] = x0_in_ff;
   assign y0_w[0] = y0_in_ff;
   assign x1_w[0] = x1_in_ff;
   assign y1_w[0] = y1_in_ff;

   for (genvar r = 0; r < MAX_CLIP_STEPS; r++) begin : g_round
      lcr_round #(.CW(CW)) u_round (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .clip_top    (clip_top_ff),
         .clip_bottom (clip_bottom_ff),
         .clip_left   (clip_left_ff),
         .clip_right  (clip_right_ff),
         .st_i        (st_w[r]),
         .x0_i        (x0_w[r]),
         .y0_i        (y0_w[r]),
         .x1_i        (x1_w[r]),
         .y1_i        (y1_w[r]),
         .st_o        (st_w[r+1]),
         .x0_o        (x0_w[r+1]),
         .y0_o        (y0_w[r+1]),
         .x1_o        (x1_w[r+1]),
         .y1_o        (y1_w[r+1])
      );
   end

   logic [3:0]                  fc0, fc1;
   logic                        vis_in, visible_ff;
   logic signed [COORD_BITS-1:0] ox0_ff, oy0_ff, ox1_ff, oy1_ff;

   always_comb begin
      fc0 = lcr_pkg::outcode(lcr_pkg::WIDE_BITS'(x0_w[MAX_CLIP_STEPS]),
                             lcr_pkg::WIDE_BITS'(y0_w[MAX_CLIP_STEPS]),
                             clip_top_ff, clip_bottom_ff, clip_left_ff, clip_right_ff);
      fc1 = lcr_pkg::outcode(lcr_pkg::WIDE_BITS'(x1_w[MAX_CLIP_STEPS]),
                             lcr_pkg::WIDE_BITS'(y1_w[MAX_CLIP_STEPS]),
                             clip_top_ff, clip_bottom_ff, clip_left_ff, clip_right_ff);
      vis_in = st_w[MAX_CLIP_STEPS].done ? st_w[MAX_CLIP_STEPS].visible
                                         : ((fc0 | fc1) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= st_w[MAX_CLIP_STEPS].valid;
      end
      if (advance) begin
         visible_ff <= vis_in;
         ox0_ff     <= vis_in ? x0_w[MAX_CLIP_STEPS][COORD_BITS-1:0] : '0;
         oy0_ff     <= vis_in ? y0_w[MAX_CLIP_STEPS][COORD_BITS-1:0] : '0;
         ox1_ff     <= vis_in ? x1_w[MAX_CLIP_STEPS][COORD_BITS-1:0] : '0;
         oy1_ff     <= vis_in ? y1_w[MAX_CLIP_STEPS][COORD_BITS-1:0] : '0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.visible     = visible_ff;
   assign rsp_bus.out_start_x = ox0_ff;
   assign rsp_bus.out_start_y = oy0_ff;
   assign rsp_bus.out_end_x   = ox1_ff;
   assign rsp_bus.out_end_y   = oy1_ff;

`ifndef SYNTHESIS
   a_invisible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.visible |-> rsp_bus.out_start_x == '0 &&
      rsp_bus.out_start_y == '0 && rsp_bus.out_end_x == '0 && rsp_bus.out_end_y == '0)
      else $error("invisible transaction carries nonzero coordinates");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input accepted while output stalled");
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_bus.valid)
      else $error("output valid right after reset");
`endif

endmodule

/* rtl/lcr_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on lcr_pkg.
module lcr_divider #(
   parameter int DW     = 21,
   parameter int SIDE_W = 102
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  lcr_pkg::status_type    st_i,
   input  logic [2*DW-1:0]        prod_i,
   input  logic [DW-1:0]          div_i,
   input  logic                   neg_i,
   input  logic [SIDE_W-1:0]      side_i,
   output lcr_pkg::status_type    st_o,
   output logic [DW-1:0]          quot_o,
   output logic                   neg_o,
   output logic [SIDE_W-1:0]      side_o
);

   lcr_pkg::status_type st_s   [DW+1];
   logic [DW-1:0]       rem_s  [DW+1];
   logic [DW-1:0]       lo_s   [DW+1];
   logic [DW-1:0]       div_s  [DW+1];
   logic                neg_s  [DW+1];
   logic [SIDE_W-1:0]   side_s [DW+1];

   assign st_s[0]   = st_i;
   assign rem_s[0]  = prod_i[2*DW-1:DW];
   assign lo_s[0]   = prod_i[DW-1:0];
   assign div_s[0]  = div_i;
   assign neg_s[0]  = neg_i;
   assign side_s[0] = side_i;

   for (genvar k = 0; k < DW; k++) begin : g_stage
      lcr_pkg::status_type st_ff;
      logic [DW-1:0]       rem_ff, rem_in;
      logic [DW-1:0]       lo_ff, lo_in;
      logic [DW-1:0]       div_ff;
      logic                neg_ff;
      logic [SIDE_W-1:0]   side_ff;
      logic [DW:0]         trial;
      logic                ge;

      always_comb begin
         trial  = {rem_s[k], lo_s[k][DW-1]};
         ge     = trial >= {1'b0, div_s[k]};
         rem_in = ge ? DW'(trial - {1'b0, div_s[k]}) : trial[DW-1:0];
         lo_in  = {lo_s[k][DW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff <= '0;
         end else if (advance) begin
            st_ff <= st_s[k];
         end
         if (advance) begin
            rem_ff  <= rem_in;
            lo_ff   <= lo_in;
            div_ff  <= div_s[k];
            neg_ff  <= neg_s[k];
            side_ff <= side_s[k];
         end
      end

      assign st_s[k+1]   = st_ff;
      assign rem_s[k+1]  = rem_ff;
      assign lo_s[k+1]   = lo_ff;
      assign div_s[k+1]  = div_ff;
      assign neg_s[k+1]  = neg_ff;
      assign side_s[k+1] = side_ff;
   end

   assign st_o   = st_s[DW];
   assign quot_o = lo_s[DW];
   assign neg_o  = neg_s[DW];
   assign side_o = side_s[DW];

endmodule

/* rtl/lcr_round.sv */
// One clip round: decide and set up, multiply, divide, move the endpoint.
// Depends on lcr_pkg and lcr_divider.
module lcr_round #(
   parameter int CW = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic signed [lcr_pkg::EDGE_BITS-1:0] clip_top,
   input  logic signed [lcr_pkg::EDGE_BITS-1:0] clip_bottom,
   input  logic signed [lcr_pkg::EDGE_BITS-1:0] clip_left,
   input  logic signed [lcr_pkg::EDGE_BITS-1:0] clip_right,
   input  lcr_pkg::status_type                 st_i,
   input  logic signed [CW-1:0]                x0_i,
   input  logic signed [CW-1:0]                y0_i,
   input  logic signed [CW-1:0]                x1_i,
   input  logic signed [CW-1:0]                y1_i,
   output lcr_pkg::status_type                 st_o,
   output logic signed [CW-1:0]                x0_o,
   output logic signed [CW-1:0]                y0_o,
   output logic signed [CW-1:0]                x1_o,
   output logic signed [CW-1:0]                y1_o
);

   localparam int DW     = CW + 1;
   localparam int SIDE_W = 5 * CW + 2;

   logic [3:0]          c0, c1, code;
   lcr_pkg::status_type st_a_in, st_a_ff;
   logic                axis_a_in, axis_a_ff, mv0_a_in, mv0_a_ff;
   logic signed [CW-1:0] e_a_in, e_a_ff;
   logic signed [DW-1:0] d_a_in, d_a_ff, num_a_in, num_a_ff, dq_a_in, dq_a_ff;
   logic signed [CW-1:0] x0_a_ff, y0_a_ff, x1_a_ff, y1_a_ff;

   always_comb begin
      c0        = lcr_pkg::outcode(lcr_pkg::WIDE_BITS'(x0_i), lcr_pkg::WIDE_BITS'(y0_i),
                                   clip_top, clip_bottom, clip_left, clip_right);
      c1        = lcr_pkg::outcode(lcr_pkg::WIDE_BITS'(x1_i), lcr_pkg::WIDE_BITS'(y1_i),
                                   clip_top, clip_bottom, clip_left, clip_right);
      st_a_in   = st_i;
      mv0_a_in  = c0 != '0;
      code      = (c0 != '0) ? c0 : c1;
      if (st_i.valid && !st_i.done) begin
         if ((c0 | c1) == '0) begin
            st_a_in.done    = 1'b1;
            st_a_in.visible = 1'b1;
         end else if ((c0 & c1) != '0) begin
            st_a_in.done    = 1'b1;
            st_a_in.visible = 1'b0;
         end
      end
      if ((code & lcr_pkg::CODE_TOP) != '0) begin
         axis_a_in = 1'b1;
         e_a_in    = CW'(lcr_pkg::edge_q(clip_top));
      end else if ((code & lcr_pkg::CODE_BOTTOM) != '0) begin
         axis_a_in = 1'b1;
         e_a_in    = CW'(lcr_pkg::edge_q(clip_bottom));
      end else if ((code & lcr_pkg::CODE_RIGHT) != '0) begin
         axis_a_in = 1'b0;
         e_a_in    = CW'(lcr_pkg::edge_q(clip_right));
      end else begin
         axis_a_in = 1'b0;
         e_a_in    = CW'(lcr_pkg::edge_q(clip_left));
      end
      if (axis_a_in) begin
         d_a_in   = DW'(x1_i) - DW'(x0_i);
         num_a_in = DW'(e_a_in) - DW'(y0_i);
         dq_a_in  = DW'(y1_i) - DW'(y0_i);
      end else begin
         d_a_in   = DW'(y1_i) - DW'(y0_i);
         num_a_in = DW'(e_a_in) - DW'(x0_i);
         dq_a_in  = DW'(x1_i) - DW'(x0_i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_a_ff <= '0;
      end else if (advance) begin
         st_a_ff <= st_a_in;
      end
      if (advance) begin
         axis_a_ff <= axis_a_in;
         mv0_a_ff  <= mv0_a_in;
         e_a_ff    <= e_a_in;
         d_a_ff    <= d_a_in;
         num_a_ff  <= num_a_in;
         dq_a_ff   <= dq_a_in;
         x0_a_ff   <= x0_i;
         y0_a_ff   <= y0_i;
         x1_a_ff   <= x1_i;
         y1_a_ff   <= y1_i;
      end
   end

   logic [DW-1:0]       mag_d, mag_num, mag_dq;
   logic [2*DW-1:0]     prod_b_in, prod_b_ff;
   logic [DW-1:0]       div_b_ff;
   logic                neg_b_in, neg_b_ff;
   logic [SIDE_W-1:0]   side_b_in, side_b_ff;
   lcr_pkg::status_type st_b_ff;

   always_comb begin
      mag_d     = d_a_ff[DW-1] ? DW'(-d_a_ff) : DW'(d_a_ff);
      mag_num   = num_a_ff[DW-1] ? DW'(-num_a_ff) : DW'(num_a_ff);
      mag_dq    = dq_a_ff[DW-1] ? DW'(-dq_a_ff) : DW'(dq_a_ff);
      prod_b_in = (2*DW)'(mag_d) * (2*DW)'(mag_num);
      neg_b_in  = d_a_ff[DW-1] ^ num_a_ff[DW-1] ^ dq_a_ff[DW-1];
      side_b_in = {x0_a_ff, y0_a_ff, x1_a_ff, y1_a_ff, e_a_ff, axis_a_ff, mv0_a_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_b_ff <= '0;
      end else if (advance) begin
         st_b_ff <= st_a_ff;
      end
      if (advance) begin
         prod_b_ff <= prod_b_in;
         div_b_ff  <= mag_dq;
         neg_b_ff  <= neg_b_in;
         side_b_ff <= side_b_in;
      end
   end

   lcr_pkg::status_type st_q;
   logic [DW-1:0]       quot_q;
   logic                neg_q;
   logic [SIDE_W-1:0]   side_q;

   lcr_divider #(.DW(DW), .SIDE_W(SIDE_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .st_i    (st_b_ff),
      .prod_i  (prod_b_ff),
      .div_i   (div_b_ff),
      .neg_i   (neg_b_ff),
      .side_i  (side_b_ff),
      .st_o    (st_q),
      .quot_o  (quot_q),
      .neg_o   (neg_q),
      .side_o  (side_q)
   );

   logic signed [CW-1:0] sx0, sy0, sx1, sy1, se, base, newc, nx, ny;
   logic                 saxis, smv0;
   logic signed [DW:0]   qs;
   logic signed [CW-1:0] x0_in, y0_in, x1_in, y1_in;
   lcr_pkg::status_type  st_ff;
   logic signed [CW-1:0] x0_ff, y0_ff, x1_ff, y1_ff;

   always_comb begin
      {sx0, sy0, sx1, sy1, se, saxis, smv0} = side_q;
      qs    = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
      base  = saxis ? sx0 : sy0;
      newc  = CW'((DW+1)'(base) + qs);
      nx    = saxis ? newc : se;
      ny    = saxis ? se : newc;
      x0_in = sx0;
      y0_in = sy0;
      x1_in = sx1;
      y1_in = sy1;
      if (st_q.valid && !st_q.done) begin
         if (smv0) begin
            x0_in = nx;
            y0_in = ny;
         end else begin
            x1_in = nx;
            y1_in = ny;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (advance) begin
         st_ff <= st_q;
      end
      if (advance) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
   end

   assign st_o = st_ff;
   assign x0_o = x0_ff;
   assign y0_o = y0_ff;
   assign x1_o = x1_ff;
   assign y1_o = y1_ff;

endmodule
